/* rtl/tcpf_pkg.sv */
// Shared types, constants and register codes of the timed color phase fader.
package tcpf_pkg;

  // Channel and color geometry
  localparam int unsigned COLOR_BITS    = 8;
  localparam int unsigned NUM_CH        = 3;
  localparam int unsigned COLOR_W       = NUM_CH * COLOR_BITS;
  localparam int unsigned CH_IDX_BITS   = 2;
  localparam logic [CH_IDX_BITS-1:0] CH_LAST = CH_IDX_BITS'(NUM_CH - 1);

  // Register geometry
  localparam int unsigned REG_BITS      = 2 * COLOR_W;
  localparam int unsigned LEN_BITS      = 16;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned TIME_BITS_DEF = 16;
  localparam int unsigned NUM_PHASES    = 4;
  localparam int unsigned PHASE_BITS    = 2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DAWN       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DAY        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUSK       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NIGHT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_LEN  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FADE_LEN   = 3'd5;

  // Input modes
  localparam logic MODE_TICK   = 1'b0;
  localparam logic MODE_SELECT = 1'b1;

  // Register reset values: start color in the upper half, end color in the lower
  localparam logic [REG_BITS-1:0] RESET_DAWN      = 48'hFF0000_FFFF00;
  localparam logic [REG_BITS-1:0] RESET_DAY       = 48'hFFFF00_00FF00;
  localparam logic [REG_BITS-1:0] RESET_DUSK      = 48'h00FF00_0000FF;
  localparam logic [REG_BITS-1:0] RESET_NIGHT     = 48'h0000FF_FF0000;
  localparam logic [LEN_BITS-1:0] RESET_PHASE_LEN = 16'd14;
  localparam logic [LEN_BITS-1:0] RESET_FADE_LEN  = 16'd5;
  localparam logic [COLOR_W-1:0]  RESET_SHOWN     = RESET_DAWN[REG_BITS-1:COLOR_W];

  typedef struct packed {
    logic                  mode;
    logic [PHASE_BITS-1:0] phase_choice;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [PHASE_BITS-1:0] active_phase;
    logic                  fading_over;
  } out_word_t;

  typedef struct packed {
    logic [NUM_PHASES-1:0][REG_BITS-1:0] colors;
    logic [LEN_BITS-1:0]                 phase_len;
    logic [LEN_BITS-1:0]                 fade_len;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                   upd;
    logic                   store_short;
    logic                   mul;
    logic                   add;
    logic                   step;
    logic                   store;
    logic                   emit;
    logic [CH_IDX_BITS-1:0] ch;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic short_seg;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_STORE,
    ST_EMIT
  } tcpf_state_e;

endpackage

/* rtl/tcpf_cfg_regs.sv */
// Configuration register file: phase colors and segment lengths.
module tcpf_cfg_regs import tcpf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [REG_BITS-1:0]     cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  // Always take writes; software must write only while the block is idle, which the block itself does not enforce
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write the addressed register, drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.colors[0] <= RESET_DAWN;
      cfg_q.colors[1] <= RESET_DAY;
      cfg_q.colors[2] <= RESET_DUSK;
      cfg_q.colors[3] <= RESET_NIGHT;
      cfg_q.phase_len <= RESET_PHASE_LEN;
      cfg_q.fade_len  <= RESET_FADE_LEN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DAWN, CFG_DAY, CFG_DUSK, CFG_NIGHT: begin
          cfg_q.colors[cfg_index_i[PHASE_BITS-1:0]] <= cfg_data_i;
        end
        CFG_PHASE_LEN: begin
          cfg_q.phase_len <= cfg_data_i[LEN_BITS-1:0];
        end
        CFG_FADE_LEN: begin
          cfg_q.fade_len <= cfg_data_i[LEN_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/tcpf_datapath.sv */
// Datapath: phase state, blend multipliers, restoring divider and output word.
module tcpf_datapath import tcpf_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  in_word_t   in_word_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_word_t  out_word_o
);

  localparam int unsigned NW = TIME_BITS + COLOR_BITS;
  localparam int unsigned LW = (TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Clamp a programmed length to the elapsed counter range
  function automatic logic [TIME_BITS-1:0] clamp_len(input logic [LEN_BITS-1:0] len);
    logic [LW-1:0] wide;
    wide = LW'(len);
    return (wide > LW'(TIME_MAX)) ? TIME_MAX : wide[TIME_BITS-1:0];
  endfunction

  logic [PHASE_BITS-1:0] phase_q;
  logic                  fade_q;
  logic [TIME_BITS-1:0]  elapsed_q;
  logic [COLOR_W-1:0]    origin_q;
  logic [COLOR_W-1:0]    shown_q;
  logic [NW-1:0]         prod_a_q;
  logic [NW-1:0]         prod_b_q;
  logic [TIME_BITS-1:0]  rem_q;
  logic [COLOR_BITS-1:0] quo_q;
  out_word_t             out_q;

  logic [TIME_BITS-1:0]  dur;
  logic [TIME_BITS-1:0]  el_inc;
  logic [REG_BITS-1:0]   phase_cols;
  logic [COLOR_W-1:0]    ph_start;
  logic [COLOR_W-1:0]    ph_end;
  logic [COLOR_W-1:0]    seg_start;
  logic [COLOR_W-1:0]    seg_end;
  logic [COLOR_BITS-1:0] cs;
  logic [COLOR_BITS-1:0] ce;
  logic [NW-1:0]         numer;
  logic [TIME_BITS:0]    trial;
  logic                  ge;

  // Segment duration and colors of the current phase or transition
  assign dur        = clamp_len(fade_q ? cfg_i.fade_len : cfg_i.phase_len);
  assign el_inc     = (elapsed_q != TIME_MAX) ? elapsed_q + TIME_BITS'(1) : elapsed_q;
  assign phase_cols = cfg_i.colors[phase_q];
  assign ph_start   = phase_cols[REG_BITS-1:COLOR_W];
  assign ph_end     = phase_cols[COLOR_W-1:0];
  assign seg_start  = fade_q ? origin_q : ph_start;
  assign seg_end    = fade_q ? ph_start : ph_end;

  // Endpoints need no division
  assign status_o.short_seg = (elapsed_q == '0) || (elapsed_q >= dur);

  // Channel operands and divider step
  assign cs    = seg_start[cmd_i.ch*COLOR_BITS +: COLOR_BITS];
  assign ce    = seg_end[cmd_i.ch*COLOR_BITS +: COLOR_BITS];
  assign numer = prod_a_q + prod_b_q;
  assign trial = {rem_q, quo_q[COLOR_BITS-1]};
  assign ge    = (trial >= {1'b0, dur});

  // Phase, fade and elapsed state; shown color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      fade_q    <= 1'b0;
      elapsed_q <= '0;
      origin_q  <= '0;
      shown_q   <= RESET_SHOWN;
    end else begin
      if (cmd_i.upd) begin
        if (in_word_i.mode == MODE_SELECT) begin
          origin_q  <= shown_q;
          phase_q   <= in_word_i.phase_choice;
          fade_q    <= 1'b1;
          elapsed_q <= '0;
        end else if (el_inc > dur) begin
          elapsed_q <= '0;
          if (fade_q) begin
            fade_q <= 1'b0;
          end else begin
            phase_q <= phase_q + PHASE_BITS'(1);
          end
        end else begin
          elapsed_q <= el_inc;
        end
      end
      if (cmd_i.store_short) begin
        shown_q <= (elapsed_q == '0) ? seg_start : seg_end;
      end
      if (cmd_i.store) begin
        shown_q[cmd_i.ch*COLOR_BITS +: COLOR_BITS] <= quo_q;
      end
    end
  end

  // Blend products, numerator load and one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_a_q <= NW'(ce) * NW'(elapsed_q);
      prod_b_q <= NW'(cs) * NW'(dur - elapsed_q);
    end
    if (cmd_i.add) begin
      rem_q <= numer[NW-1:COLOR_BITS];
      quo_q <= numer[COLOR_BITS-1:0];
    end else if (cmd_i.step) begin
      rem_q <= ge ? trial[TIME_BITS-1:0] - dur : trial[TIME_BITS-1:0];
      quo_q <= {quo_q[COLOR_BITS-2:0], ge};
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.red          <= shown_q[3*COLOR_BITS-1:2*COLOR_BITS];
      out_q.green        <= shown_q[2*COLOR_BITS-1:COLOR_BITS];
      out_q.blue         <= shown_q[COLOR_BITS-1:0];
      out_q.active_phase <= phase_q;
      out_q.fading_over  <= fade_q;
    end
  end

  assign out_word_o = out_q;

endmodule

/* rtl/tcpf_ctrl.sv */
// Controller: sequences state update, per-channel blend and result handoff.
module tcpf_ctrl import tcpf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int unsigned STEP_BITS = $clog2(COLOR_BITS);
  localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(COLOR_BITS - 1);

  tcpf_state_e            state_q, state_d;
  logic [CH_IDX_BITS-1:0] ch_q, ch_d;
  logic [STEP_BITS-1:0]   step_q, step_d;
  logic                   out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // State, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.ch    = ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_SETUP;
        end
      end
      ST_SETUP: begin
        ch_d = '0;
        if (status_i.short_seg) begin
          cmd_o.store_short = 1'b1;
          state_d           = ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        step_d    = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + STEP_BITS'(1);
        if (step_q == STEP_LAST) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (ch_q == CH_LAST) begin
          state_d = ST_EMIT;
        end else begin
          ch_d    = ch_q + CH_IDX_BITS'(1);
          state_d = ST_MUL;
        end
      end
      ST_EMIT: begin
        // Hand off once the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SETUP))
    else $error("accepted word did not start setup");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && step_q == STEP_LAST) |=> (state_q == ST_STORE))
    else $error("divider ran past its last quotient bit");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a word still waiting");

  a_channel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (ch_q <= CH_LAST))
    else $error("channel counter out of range");
`endif

endmodule

/* rtl/timed_color_phase_fader.sv */
// Top level of the timed color phase fader.
// Every input word (a tick or a phase select) yields one result word with
// the shown color, the active phase and the transition flag. When the shown
// color is a segment endpoint (first tick of a segment, or at or past its
// length) a word goes from setup straight to the emit state; in the middle
// of a fade the shared restoring divider produces one quotient bit per
// cycle for each of the three channels in turn, each after a multiply and
// a numerator load. A finished result waits in the output register while
// the next word is accepted. The configuration port always shows ready;
// writes to unknown indexes are dropped, and writes should happen only
// while the block is idle.
module timed_color_phase_fader import tcpf_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_word_t               out_word_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [REG_BITS-1:0]     cfg_data_i
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  tcpf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tcpf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcpf_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule
